@@ rtl/vnet_pkg.sv @@
package vnet_pkg;

   // Default geometry
   localparam int QUEUE_COUNT_DEF  = 2;
   localparam int QUEUE_MAX_DEF    = 64;
   localparam int WINDOW_BYTES_DEF = 512;

   // Field widths
   localparam int OFFSET_W = 9;
   localparam int AWIDTH_W = 3;
   localparam int DATA_W   = 32;
   localparam int MAC_W    = 48;
   localparam int ADDR_W   = 64;

   // Item kinds
   typedef enum logic [1:0] {
      REQ_READ  = 2'd0,
      REQ_WRITE = 2'd1,
      REQ_LINK  = 2'd2,
      REQ_DONE  = 2'd3
   } req_kind_type;

   // Register map
   localparam logic [OFFSET_W-1:0] OFF_MAGIC        = 9'h000;
   localparam logic [OFFSET_W-1:0] OFF_VERSION      = 9'h004;
   localparam logic [OFFSET_W-1:0] OFF_DEVICE_ID    = 9'h008;
   localparam logic [OFFSET_W-1:0] OFF_VENDOR_ID    = 9'h00c;
   localparam logic [OFFSET_W-1:0] OFF_DEV_FEAT     = 9'h010;
   localparam logic [OFFSET_W-1:0] OFF_DEV_FEAT_SEL = 9'h014;
   localparam logic [OFFSET_W-1:0] OFF_DRV_FEAT     = 9'h020;
   localparam logic [OFFSET_W-1:0] OFF_DRV_FEAT_SEL = 9'h024;
   localparam logic [OFFSET_W-1:0] OFF_QUEUE_SEL    = 9'h030;
   localparam logic [OFFSET_W-1:0] OFF_QUEUE_MAX    = 9'h034;
   localparam logic [OFFSET_W-1:0] OFF_QUEUE_NUM    = 9'h038;
   localparam logic [OFFSET_W-1:0] OFF_QUEUE_READY  = 9'h044;
   localparam logic [OFFSET_W-1:0] OFF_QUEUE_NOTIFY = 9'h050;
   localparam logic [OFFSET_W-1:0] OFF_INT_STATUS   = 9'h060;
   localparam logic [OFFSET_W-1:0] OFF_INT_ACK      = 9'h064;
   localparam logic [OFFSET_W-1:0] OFF_STATUS       = 9'h070;
   localparam logic [OFFSET_W-1:0] OFF_DESC_LO      = 9'h080;
   localparam logic [OFFSET_W-1:0] OFF_DESC_HI      = 9'h084;
   localparam logic [OFFSET_W-1:0] OFF_AVAIL_LO     = 9'h090;
   localparam logic [OFFSET_W-1:0] OFF_AVAIL_HI     = 9'h094;
   localparam logic [OFFSET_W-1:0] OFF_USED_LO      = 9'h0a0;
   localparam logic [OFFSET_W-1:0] OFF_USED_HI      = 9'h0a4;
   localparam logic [OFFSET_W-1:0] OFF_GENERATION   = 9'h0fc;
   localparam logic [OFFSET_W-1:0] CFG_BASE         = 9'h100;

   // Fixed register values
   localparam logic [DATA_W-1:0] MAGIC_VALUE     = 32'h7472_6976;
   localparam logic [DATA_W-1:0] VERSION_VALUE   = 32'd2;
   localparam logic [DATA_W-1:0] DEVICE_ID_VALUE = 32'd1;
   localparam logic [DATA_W-1:0] VENDOR_VALUE    = 32'h0050_5345;
   localparam logic [DATA_W-1:0] FEATURES_LO     = 32'h0001_0020;
   localparam logic [DATA_W-1:0] FEATURES_HI     = 32'h0000_0001;
   localparam int                STATUS_DRV_OK   = 2;
   localparam logic [MAC_W-1:0]  MAC_RESET       = 48'h0100_0034_5002;

   typedef struct packed {
      logic [1:0]          req_type;
      logic [OFFSET_W-1:0] offset;
      logic [AWIDTH_W-1:0] access_width;
      logic [DATA_W-1:0]   write_data;
      logic                link_up;
      logic                interrupt_suppressed;
   } req_item_type;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic              irq_pending;
      logic              kick;
      logic              driver_ok;
   } rsp_item_type;

endpackage

@@ rtl/vnet_if.sv @@
interface vnet_req_if;
   import vnet_pkg::*;

   logic                valid;
   logic                ready;
   logic [1:0]          req_type;
   logic [OFFSET_W-1:0] offset;
   logic [AWIDTH_W-1:0] access_width;
   logic [DATA_W-1:0]   write_data;
   logic                link_up;
   logic                interrupt_suppressed;

   modport source (output valid, req_type, offset, access_width, write_data, link_up,
                   interrupt_suppressed, input ready);
   modport sink (input valid, req_type, offset, access_width, write_data, link_up,
                 interrupt_suppressed, output ready);
endinterface

interface vnet_rsp_if;
   import vnet_pkg::*;

   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] read_data;
   logic              irq_pending;
   logic              kick;
   logic              driver_ok;

   modport source (output valid, read_data, irq_pending, kick, driver_ok, input ready);
   modport sink (input valid, read_data, irq_pending, kick, driver_ok, output ready);
endinterface

interface vnet_csr_if;
   import vnet_pkg::*;

   logic             valid;
   logic             ready;
   logic [MAC_W-1:0] mac_address;

   modport source (output valid, mac_address, input ready);
   modport sink (input valid, mac_address, output ready);
endinterface

@@ rtl/virtio_mmio_net_register_file.sv @@
// Register file of a virtio-mmio version 2 network device. Each item on the
// req_ channel is a bus read, a bus write, a link event or a ring completion;
// each gives exactly one item on the rsp_ channel with read data, the IRQ
// level, a kick pulse for the ring engine and the DRIVER_OK status bit. The
// block takes one item every clock cycle: an item sits in the input register
// while the register decode and update run, and its result is then held in
// the output register until the rsp_ channel takes it. Throughput drops only
// while rsp_ready holds a result back. The station MAC is written through the
// csr_ channel, which is always ready; it shows in config space at 0x100
// ahead of the link status word.
module virtio_mmio_net_register_file #(
   parameter int QUEUE_COUNT  = vnet_pkg::QUEUE_COUNT_DEF,
   parameter int QUEUE_MAX    = vnet_pkg::QUEUE_MAX_DEF,
   parameter int WINDOW_BYTES = vnet_pkg::WINDOW_BYTES_DEF
) (
   input logic       clock,
   input logic       reset,
   vnet_req_if.sink  req_chan,
   vnet_rsp_if.source rsp_chan,
   vnet_csr_if.sink  csr_chan
);
   import vnet_pkg::*;

   logic             in_valid_ff;
   req_item_type     in_item_ff;
   logic             out_valid_ff;
   rsp_item_type     out_item_ff;
   logic [MAC_W-1:0] mac_ff;
   rsp_item_type     result;
   logic             advance;
   logic             take;

   // Move the item on when the output register is free or being drained
   assign advance = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign take    = req_chan.valid && req_chan.ready;

   assign req_chan.ready = !in_valid_ff || advance;
   assign csr_chan.ready = 1'b1;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_item_ff.req_type             <= req_chan.req_type;
         in_item_ff.offset               <= req_chan.offset;
         in_item_ff.access_width         <= req_chan.access_width;
         in_item_ff.write_data           <= req_chan.write_data;
         in_item_ff.link_up              <= req_chan.link_up;
         in_item_ff.interrupt_suppressed <= req_chan.interrupt_suppressed;
      end
   end

   // Station MAC
   always_ff @(posedge clock) begin
      if (reset) begin
         mac_ff <= MAC_RESET;
      end else if (csr_chan.valid) begin
         mac_ff <= csr_chan.mac_address;
      end
   end

   vnet_regs #(
      .QUEUE_COUNT  (QUEUE_COUNT),
      .QUEUE_MAX    (QUEUE_MAX),
      .WINDOW_BYTES (WINDOW_BYTES)
   ) u_regs (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (in_item_ff),
      .mac    (mac_ff),
      .result (result)
   );

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_item_ff <= result;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.read_data   = out_item_ff.read_data;
   assign rsp_chan.irq_pending = out_item_ff.irq_pending;
   assign rsp_chan.kick        = out_item_ff.kick;
   assign rsp_chan.driver_ok   = out_item_ff.driver_ok;

endmodule

@@ rtl/vnet_regs.sv @@
module vnet_regs #(
   parameter int QUEUE_COUNT  = vnet_pkg::QUEUE_COUNT_DEF,
   parameter int QUEUE_MAX    = vnet_pkg::QUEUE_MAX_DEF,
   parameter int WINDOW_BYTES = vnet_pkg::WINDOW_BYTES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         fire,
   input  vnet_pkg::req_item_type       item,
   input  logic [vnet_pkg::MAC_W-1:0]   mac,
   output vnet_pkg::rsp_item_type       result
);
   import vnet_pkg::*;

   localparam int QIDX_W  = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
   localparam int QSIZE_W = $clog2(QUEUE_MAX + 1);
   localparam int END_W   = 13;

   // Device state
   logic [QSIZE_W-1:0] qsize_ff  [QUEUE_COUNT];
   logic [QSIZE_W-1:0] qsize_in  [QUEUE_COUNT];
   logic               qready_ff [QUEUE_COUNT];
   logic               qready_in [QUEUE_COUNT];
   logic [ADDR_W-1:0]  desc_ff   [QUEUE_COUNT];
   logic [ADDR_W-1:0]  desc_in   [QUEUE_COUNT];
   logic [ADDR_W-1:0]  avail_ff  [QUEUE_COUNT];
   logic [ADDR_W-1:0]  avail_in  [QUEUE_COUNT];
   logic [ADDR_W-1:0]  used_ff   [QUEUE_COUNT];
   logic [ADDR_W-1:0]  used_in   [QUEUE_COUNT];
   logic [DATA_W-1:0]  dev_sel_ff, dev_sel_in;
   logic [DATA_W-1:0]  drv_sel_ff, drv_sel_in;
   logic [DATA_W-1:0]  drv_feat_ff [2];
   logic [DATA_W-1:0]  drv_feat_in [2];
   logic [DATA_W-1:0]  qsel_ff, qsel_in;
   logic [DATA_W-1:0]  status_ff, status_in;
   logic [1:0]         ibits_ff, ibits_in;
   logic [DATA_W-1:0]  gen_ff, gen_in;
   logic               link_ff, link_in;

   // Decode
   logic [END_W-1:0]   win_end;
   logic               in_range;
   logic               is_cfg;
   logic               reg_access;
   logic               qv;
   logic [QIDX_W-1:0]  qidx;
   logic [7:0]         cfg_pos;
   logic               cfg_fits;
   logic [63:0]        cfg_word;
   logic [63:0]        cfg_shift;
   logic [DATA_W-1:0]  cfg_mask;
   logic [DATA_W-1:0]  reg_rd;
   logic [DATA_W-1:0]  rd;
   logic               kick;

   assign win_end    = END_W'(item.offset) + END_W'(item.access_width);
   assign in_range   = (item.access_width >= 3'd1) && (item.access_width <= 3'd4) &&
                       (win_end <= END_W'(WINDOW_BYTES));
   assign is_cfg     = (item.offset >= CFG_BASE);
   assign reg_access = in_range && !is_cfg && (item.access_width == 3'd4);
   assign qv         = (qsel_ff < DATA_W'(QUEUE_COUNT));
   assign qidx       = qv ? qsel_ff[QIDX_W-1:0] : '0;

   // Config space: six MAC bytes, then the link status word
   assign cfg_pos   = item.offset[7:0] - CFG_BASE[7:0];
   assign cfg_fits  = (cfg_pos < 8'd8) &&
                      ((9'(cfg_pos) + 9'(item.access_width)) <= 9'd8);
   assign cfg_word  = {8'h00, 7'b0, link_ff, mac};
   assign cfg_shift = cfg_word >> {cfg_pos[2:0], 3'b000};

   always_comb begin
      case (item.access_width)
         3'd1:    cfg_mask = 32'h0000_00ff;
         3'd2:    cfg_mask = 32'h0000_ffff;
         3'd3:    cfg_mask = 32'h00ff_ffff;
         default: cfg_mask = 32'hffff_ffff;
      endcase
   end

   // Register read mux
   always_comb begin
      case (item.offset)
         OFF_MAGIC:       reg_rd = MAGIC_VALUE;
         OFF_VERSION:     reg_rd = VERSION_VALUE;
         OFF_DEVICE_ID:   reg_rd = DEVICE_ID_VALUE;
         OFF_VENDOR_ID:   reg_rd = VENDOR_VALUE;
         OFF_DEV_FEAT: begin
            if (dev_sel_ff == 32'd0) begin
               reg_rd = FEATURES_LO;
            end else if (dev_sel_ff == 32'd1) begin
               reg_rd = FEATURES_HI;
            end else begin
               reg_rd = '0;
            end
         end
         OFF_QUEUE_MAX:   reg_rd = qv ? DATA_W'(QUEUE_MAX) : '0;
         OFF_QUEUE_READY: reg_rd = qv ? DATA_W'(qready_ff[qidx]) : '0;
         OFF_INT_STATUS:  reg_rd = DATA_W'(ibits_ff);
         OFF_STATUS:      reg_rd = status_ff;
         OFF_GENERATION:  reg_rd = gen_ff;
         default:         reg_rd = '0;
      endcase
   end

   always_comb begin
      rd = '0;
      if (item.req_type == REQ_READ && in_range) begin
         if (is_cfg) begin
            rd = cfg_fits ? (cfg_shift[DATA_W-1:0] & cfg_mask) : '0;
         end else if (item.access_width == 3'd4) begin
            rd = reg_rd;
         end
      end
   end

   // Next state for the item in hand
   always_comb begin
      qsize_in    = qsize_ff;
      qready_in   = qready_ff;
      desc_in     = desc_ff;
      avail_in    = avail_ff;
      used_in     = used_ff;
      dev_sel_in  = dev_sel_ff;
      drv_sel_in  = drv_sel_ff;
      drv_feat_in = drv_feat_ff;
      qsel_in     = qsel_ff;
      status_in   = status_ff;
      ibits_in    = ibits_ff;
      gen_in      = gen_ff;
      link_in     = link_ff;
      kick        = 1'b0;

      case (item.req_type)
         REQ_WRITE: begin
            if (reg_access) begin
               case (item.offset)
                  OFF_DEV_FEAT_SEL: dev_sel_in = item.write_data;
                  OFF_DRV_FEAT_SEL: drv_sel_in = item.write_data;
                  OFF_DRV_FEAT: begin
                     if (drv_sel_ff < 32'd2) begin
                        drv_feat_in[drv_sel_ff[0]] = item.write_data;
                     end
                  end
                  OFF_QUEUE_SEL: qsel_in = item.write_data;
                  OFF_QUEUE_NUM: begin
                     if (qv && item.write_data <= DATA_W'(QUEUE_MAX)) begin
                        qsize_in[qidx] = item.write_data[QSIZE_W-1:0];
                     end
                  end
                  OFF_QUEUE_READY: if (qv) qready_in[qidx] = item.write_data[0];
                  OFF_DESC_LO:  if (qv) desc_in[qidx][31:0]   = item.write_data;
                  OFF_DESC_HI:  if (qv) desc_in[qidx][63:32]  = item.write_data;
                  OFF_AVAIL_LO: if (qv) avail_in[qidx][31:0]  = item.write_data;
                  OFF_AVAIL_HI: if (qv) avail_in[qidx][63:32] = item.write_data;
                  OFF_USED_LO:  if (qv) used_in[qidx][31:0]   = item.write_data;
                  OFF_USED_HI:  if (qv) used_in[qidx][63:32]  = item.write_data;
                  OFF_QUEUE_NOTIFY: kick = (item.write_data < DATA_W'(QUEUE_COUNT));
                  OFF_INT_ACK: ibits_in = ibits_ff & ~item.write_data[1:0];
                  OFF_STATUS: begin
                     kick = item.write_data[STATUS_DRV_OK];
                     if (item.write_data == '0) begin
                        // Device reset: keep generation and link
                        for (int q = 0; q < QUEUE_COUNT; q++) begin
                           qsize_in[q]  = '0;
                           qready_in[q] = 1'b0;
                           desc_in[q]   = '0;
                           avail_in[q]  = '0;
                           used_in[q]   = '0;
                        end
                        drv_feat_in[0] = '0;
                        drv_feat_in[1] = '0;
                        dev_sel_in     = '0;
                        drv_sel_in     = '0;
                        qsel_in        = '0;
                        status_in      = '0;
                        ibits_in       = '0;
                     end else begin
                        status_in = item.write_data;
                     end
                  end
                  default: ;
               endcase
            end
         end
         REQ_LINK: begin
            if (item.link_up != link_ff) begin
               link_in     = item.link_up;
               gen_in      = gen_ff + 32'd1;
               ibits_in[1] = 1'b1;
            end
         end
         REQ_DONE: begin
            if (!item.interrupt_suppressed) begin
               ibits_in[0] = 1'b1;
            end
         end
         default: ;
      endcase
   end

   assign result.read_data   = rd;
   assign result.irq_pending = (ibits_in != 2'b00);
   assign result.kick        = kick;
   assign result.driver_ok   = status_in[STATUS_DRV_OK];

   // Commit state when the item leaves the input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int q = 0; q < QUEUE_COUNT; q++) begin
            qsize_ff[q]  <= '0;
            qready_ff[q] <= 1'b0;
            desc_ff[q]   <= '0;
            avail_ff[q]  <= '0;
            used_ff[q]   <= '0;
         end
         dev_sel_ff     <= '0;
         drv_sel_ff     <= '0;
         drv_feat_ff[0] <= '0;
         drv_feat_ff[1] <= '0;
         qsel_ff        <= '0;
         status_ff      <= '0;
         ibits_ff       <= '0;
         gen_ff         <= '0;
         link_ff        <= 1'b0;
      end else if (fire) begin
         qsize_ff    <= qsize_in;
         qready_ff   <= qready_in;
         desc_ff     <= desc_in;
         avail_ff    <= avail_in;
         used_ff     <= used_in;
         dev_sel_ff  <= dev_sel_in;
         drv_sel_ff  <= drv_sel_in;
         drv_feat_ff <= drv_feat_in;
         qsel_ff     <= qsel_in;
         status_ff   <= status_in;
         ibits_ff    <= ibits_in;
         gen_ff      <= gen_in;
         link_ff     <= link_in;
      end
   end

   // Queue sizes never exceed the advertised maximum
   for (genvar q = 0; q < QUEUE_COUNT; q++) begin : g_qchk
      a_qsize_max: assert property (@(posedge clock) disable iff (reset)
         qsize_ff[q] <= QSIZE_W'(QUEUE_MAX))
         else $error("queue size above maximum");

      // A status write of zero clears every ring address
      a_status_clear: assert property (@(posedge clock) disable iff (reset)
         fire && item.req_type == REQ_WRITE && item.offset == OFF_STATUS &&
         item.access_width == 3'd4 && item.write_data == '0
         |=> desc_ff[q] == '0 && avail_ff[q] == '0 && used_ff[q] == '0 &&
             !qready_ff[q] && status_ff == '0 && qsel_ff == '0)
         else $error("device reset left queue state");
   end

   // A link change bumps the generation and raises the config interrupt
   a_link_gen: assert property (@(posedge clock) disable iff (reset)
      fire && item.req_type == REQ_LINK && item.link_up != link_ff
      |=> gen_ff == $past(gen_ff) + 32'd1 && ibits_ff[1])
      else $error("link change not recorded");

   // State holds while no item commits
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(gen_ff) && $stable(ibits_ff) && $stable(status_ff))
      else $error("state changed without an item");

endmodule

@@ dv/virtio_mmio_net_register_file_tb.sv @@
`timescale 1ns / 100ps

module virtio_mmio_net_register_file_tb;
   import vnet_pkg::*;

   localparam int QCOUNT = QUEUE_COUNT_DEF;
   localparam int QMAX   = QUEUE_MAX_DEF;
   localparam int WINDOW = WINDOW_BYTES_DEF;

   // Device status bits written during driver bring-up
   localparam logic [DATA_W-1:0] ST_ACK     = 32'h1;
   localparam logic [DATA_W-1:0] ST_DRIVER  = 32'h2;
   localparam logic [DATA_W-1:0] ST_FEAT_OK = 32'h8;
   localparam logic [DATA_W-1:0] ST_DRV_OK  = 32'h1 << STATUS_DRV_OK;

   logic clock = 1'b0;
   logic reset;

   vnet_req_if req_bus ();
   vnet_rsp_if rsp_bus ();
   vnet_csr_if csr_bus ();

   virtio_mmio_net_register_file uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copy of the device registers
   logic [MAC_W-1:0]  mac_shadow;
   logic [6:0]        q_size  [QCOUNT];
   logic              q_ready [QCOUNT];
   logic [ADDR_W-1:0] q_desc  [QCOUNT];
   logic [ADDR_W-1:0] q_avail [QCOUNT];
   logic [ADDR_W-1:0] q_used  [QCOUNT];
   logic [DATA_W-1:0] dev_feat_sel;
   logic [DATA_W-1:0] drv_feat_sel;
   logic [DATA_W-1:0] drv_feat_word [2];
   logic [DATA_W-1:0] q_select;
   logic [DATA_W-1:0] dev_status;
   logic [1:0]        irq_bits;
   logic [DATA_W-1:0] gen_count;
   logic              link_now;

   req_item_type access_queue [$];
   rsp_item_type predicted_rsp [$];
   int           accesses_queued = 0;
   int           accesses_taken  = 0;
   int           rsp_checked     = 0;
   int           error_count     = 0;

   // Device reset: everything but generation count and link state
   function automatic void clear_device_state();
      int i;
      for (i = 0; i < QCOUNT; i++) begin
         q_size[i]  = '0;
         q_ready[i] = 1'b0;
         q_desc[i]  = '0;
         q_avail[i] = '0;
         q_used[i]  = '0;
      end
      drv_feat_word[0] = '0;
      drv_feat_word[1] = '0;
      dev_feat_sel     = '0;
      drv_feat_sel     = '0;
      q_select         = '0;
      dev_status       = '0;
      irq_bits         = '0;
   endfunction

   // Apply one access to the shadow registers and return the response it gives
   function automatic rsp_item_type apply_access(input req_item_type it);
      rsp_item_type      r;
      int unsigned       off;
      int unsigned       w;
      int unsigned       pos;
      int                q;
      int                i;
      logic [DATA_W-1:0] d;
      logic              qv;
      logic              in_window;
      logic [7:0]        cfg_bytes [8];
      r   = '0;
      off = it.offset;
      w   = it.access_width;
      d   = it.write_data;
      qv  = q_select < 32'(QCOUNT);
      q   = qv ? int'(q_select) : 0;
      in_window = w >= 1 && w <= 4 && off + w <= WINDOW;
      for (i = 0; i < 6; i++) cfg_bytes[i] = mac_shadow[8*i +: 8];
      cfg_bytes[6] = {7'b0, link_now};
      cfg_bytes[7] = 8'h00;

      case (it.req_type)
         REQ_READ: begin
            if (in_window && off >= CFG_BASE) begin
               // Config space: little-endian over MAC then link status
               pos = off - CFG_BASE;
               if (pos < 8 && w <= 8 - pos)
                  for (i = 0; i < int'(w); i++) r.read_data[8*i +: 8] = cfg_bytes[pos + i];
            end else if (in_window && w == 4) begin
               case (it.offset)
                  OFF_MAGIC:       r.read_data = MAGIC_VALUE;
                  OFF_VERSION:     r.read_data = VERSION_VALUE;
                  OFF_DEVICE_ID:   r.read_data = DEVICE_ID_VALUE;
                  OFF_VENDOR_ID:   r.read_data = VENDOR_VALUE;
                  OFF_DEV_FEAT: begin
                     if (dev_feat_sel == 32'd0) r.read_data = FEATURES_LO;
                     else if (dev_feat_sel == 32'd1) r.read_data = FEATURES_HI;
                  end
                  OFF_QUEUE_MAX:   r.read_data = qv ? 32'(QMAX) : 32'd0;
                  OFF_QUEUE_READY: r.read_data = qv ? {31'b0, q_ready[q]} : 32'd0;
                  OFF_INT_STATUS:  r.read_data = {30'b0, irq_bits};
                  OFF_STATUS:      r.read_data = dev_status;
                  OFF_GENERATION:  r.read_data = gen_count;
                  default:         r.read_data = '0;
               endcase
            end
         end
         REQ_WRITE: begin
            if (in_window && w == 4 && off < CFG_BASE) begin
               case (it.offset)
                  OFF_DEV_FEAT_SEL: dev_feat_sel = d;
                  OFF_DRV_FEAT_SEL: drv_feat_sel = d;
                  OFF_DRV_FEAT:
                     if (drv_feat_sel < 32'd2) drv_feat_word[drv_feat_sel[0]] = d;
                  OFF_QUEUE_SEL:    q_select = d;
                  OFF_QUEUE_NUM:
                     if (qv && d <= 32'(QMAX)) q_size[q] = d[6:0];
                  OFF_QUEUE_READY:  if (qv) q_ready[q] = d[0];
                  OFF_DESC_LO:      if (qv) q_desc[q][31:0]  = d;
                  OFF_DESC_HI:      if (qv) q_desc[q][63:32] = d;
                  OFF_AVAIL_LO:     if (qv) q_avail[q][31:0]  = d;
                  OFF_AVAIL_HI:     if (qv) q_avail[q][63:32] = d;
                  OFF_USED_LO:      if (qv) q_used[q][31:0]  = d;
                  OFF_USED_HI:      if (qv) q_used[q][63:32] = d;
                  OFF_QUEUE_NOTIFY: r.kick = d < 32'(QCOUNT);
                  OFF_INT_ACK:      irq_bits = irq_bits & ~d[1:0];
                  OFF_STATUS: begin
                     if (d == 32'd0) clear_device_state();
                     else dev_status = d;
                     r.kick = d[STATUS_DRV_OK];
                  end
                  default: ;
               endcase
            end
         end
         REQ_LINK: begin
            // Only a change of link state counts
            if (it.link_up != link_now) begin
               link_now    = it.link_up;
               gen_count   = gen_count + 32'd1;
               irq_bits[1] = 1'b1;
            end
         end
         default: begin
            if (!it.interrupt_suppressed) irq_bits[0] = 1'b1;
         end
      endcase

      r.irq_pending = irq_bits != 2'b00;
      r.driver_ok   = dev_status[STATUS_DRV_OK];
      return r;
   endfunction

   function automatic req_item_type build_access(input req_kind_type kind,
                                                 input logic [OFFSET_W-1:0] off,
                                                 input logic [AWIDTH_W-1:0] w,
                                                 input logic [DATA_W-1:0] d,
                                                 input logic up = 1'b0,
                                                 input logic quiet = 1'b0);
      req_item_type it;
      it.req_type             = kind;
      it.offset               = off;
      it.access_width         = w;
      it.write_data           = d;
      it.link_up              = up;
      it.interrupt_suppressed = quiet;
      return it;
   endfunction

   function automatic void push_item(input req_item_type it);
      access_queue.push_back(it);
      accesses_queued++;
   endfunction

   function automatic logic [OFFSET_W-1:0] random_register();
      case ($urandom_range(0, 22))
         0:       return OFF_MAGIC;
         1:       return OFF_VERSION;
         2:       return OFF_DEVICE_ID;
         3:       return OFF_VENDOR_ID;
         4:       return OFF_DEV_FEAT;
         5:       return OFF_DEV_FEAT_SEL;
         6:       return OFF_DRV_FEAT;
         7:       return OFF_DRV_FEAT_SEL;
         8:       return OFF_QUEUE_SEL;
         9:       return OFF_QUEUE_MAX;
         10:      return OFF_QUEUE_NUM;
         11:      return OFF_QUEUE_READY;
         12:      return OFF_QUEUE_NOTIFY;
         13:      return OFF_INT_STATUS;
         14:      return OFF_INT_ACK;
         15:      return OFF_STATUS;
         16:      return OFF_DESC_LO;
         17:      return OFF_DESC_HI;
         18:      return OFF_AVAIL_LO;
         19:      return OFF_AVAIL_HI;
         20:      return OFF_USED_LO;
         21:      return OFF_USED_HI;
         default: return OFF_GENERATION;
      endcase
   endfunction

   // Typical driver bring-up: status steps, features, then every queue
   function automatic void add_bringup();
      int s;
      int q;
      push_item(build_access(REQ_WRITE, OFF_STATUS, 3'd4, ST_ACK));
      push_item(build_access(REQ_WRITE, OFF_STATUS, 3'd4, ST_ACK | ST_DRIVER));
      for (s = 0; s < 2; s++) begin
         push_item(build_access(REQ_WRITE, OFF_DEV_FEAT_SEL, 3'd4, 32'(s)));
         push_item(build_access(REQ_READ, OFF_DEV_FEAT, 3'd4, 32'd0));
         push_item(build_access(REQ_WRITE, OFF_DRV_FEAT_SEL, 3'd4, 32'(s)));
         push_item(build_access(REQ_WRITE, OFF_DRV_FEAT, 3'd4, $urandom));
      end
      push_item(build_access(REQ_WRITE, OFF_STATUS, 3'd4, ST_ACK | ST_DRIVER | ST_FEAT_OK));
      push_item(build_access(REQ_READ, OFF_STATUS, 3'd4, 32'd0));
      for (q = 0; q < QCOUNT; q++) begin
         push_item(build_access(REQ_WRITE, OFF_QUEUE_SEL, 3'd4, 32'(q)));
         push_item(build_access(REQ_READ, OFF_QUEUE_MAX, 3'd4, 32'd0));
         push_item(build_access(REQ_WRITE, OFF_QUEUE_NUM, 3'd4, $urandom_range(1, QMAX)));
         push_item(build_access(REQ_WRITE, OFF_DESC_LO, 3'd4, $urandom));
         push_item(build_access(REQ_WRITE, OFF_DESC_HI, 3'd4, $urandom));
         push_item(build_access(REQ_WRITE, OFF_AVAIL_LO, 3'd4, $urandom));
         push_item(build_access(REQ_WRITE, OFF_AVAIL_HI, 3'd4, $urandom));
         push_item(build_access(REQ_WRITE, OFF_USED_LO, 3'd4, $urandom));
         push_item(build_access(REQ_WRITE, OFF_USED_HI, 3'd4, $urandom));
         push_item(build_access(REQ_WRITE, OFF_QUEUE_READY, 3'd4, 32'd1));
         push_item(build_access(REQ_READ, OFF_QUEUE_READY, 3'd4, 32'd0));
      end
      push_item(build_access(REQ_WRITE, OFF_STATUS, 3'd4,
                             ST_ACK | ST_DRIVER | ST_FEAT_OK | ST_DRV_OK));
   endfunction

   // Running-device traffic: notifies, completions, link flaps, acks, polls
   function automatic req_item_type random_traffic_item();
      logic [DATA_W-1:0] d;
      d = $urandom;
      case ($urandom_range(0, 15))
         0, 1, 2: return build_access(REQ_WRITE, OFF_QUEUE_NOTIFY, 3'd4, $urandom_range(0, 3));
         3, 4:    return build_access(REQ_DONE, 9'($urandom), 3'($urandom), d,
                                      1'($urandom), 1'($urandom));
         5:       return build_access(REQ_LINK, 9'($urandom), 3'($urandom), d,
                                      1'($urandom), 1'($urandom));
         6:       return build_access(REQ_READ, OFF_INT_STATUS, 3'd4, 32'd0);
         7:       return build_access(REQ_WRITE, OFF_INT_ACK, 3'd4,
                                      $urandom_range(0, 1) ? $urandom_range(0, 3) : d);
         8:       return build_access(REQ_READ, random_register(), 3'd4, 32'd0);
         9:       return build_access(REQ_READ, 9'(CFG_BASE + 9'($urandom_range(0, 9))),
                                      3'($urandom_range(1, 4)), 32'd0);
         10:      return build_access(REQ_WRITE, random_register(), 3'd4, d);
         11:      return build_access(REQ_READ, $urandom_range(0, 1) ? OFF_STATUS
                                      : OFF_GENERATION, 3'd4, 32'd0);
         12:      return build_access(REQ_WRITE, OFF_QUEUE_SEL, 3'd4,
                                      ($urandom_range(0, 7) == 0) ? d : $urandom_range(0, 2));
         13:      return build_access($urandom_range(0, 1) ? REQ_WRITE : REQ_READ,
                                      OFF_QUEUE_READY, 3'd4, d);
         14:      return build_access(REQ_WRITE, OFF_STATUS, 3'd4,
                                      ($urandom_range(0, 5) == 0) ? 32'd0 : $urandom_range(1, 15));
         default: return build_access(REQ_WRITE, OFF_QUEUE_NUM, 3'd4, $urandom_range(0, 80));
      endcase
   endfunction

   // Block until every queued item was taken and every response checked
   task automatic wait_idle(input int settle);
      while (accesses_taken != accesses_queued || predicted_rsp.size() != 0)
         @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_station_mac(input logic [MAC_W-1:0] value);
      @(posedge clock);
      csr_bus.valid       <= 1'b1;
      csr_bus.mac_address <= value;
      do @(posedge clock); while (!csr_bus.ready);
      mac_shadow = value;
      csr_bus.valid <= 1'b0;
   endtask

   // Stimulus: directed checks at the reset MAC, then random phases per MAC
   initial begin
      int           phase;
      int           phase_target;
      int unsigned  pick;
      logic [MAC_W-1:0] phase_mac;
      reset                        = 1'b1;
      req_bus.valid                = 1'b0;
      req_bus.req_type             = '0;
      req_bus.offset               = '0;
      req_bus.access_width         = '0;
      req_bus.write_data           = '0;
      req_bus.link_up              = 1'b0;
      req_bus.interrupt_suppressed = 1'b0;
      rsp_bus.ready                = 1'b0;
      csr_bus.valid                = 1'b0;
      csr_bus.mac_address          = '0;
      mac_shadow                   = MAC_RESET;
      clear_device_state();
      gen_count = '0;
      link_now  = 1'b0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      push_item(build_access(REQ_READ, OFF_MAGIC, 3'd4, 32'd0));
      push_item(build_access(REQ_READ, OFF_DEV_FEAT, 3'd4, 32'd0));
      push_item(build_access(REQ_WRITE, OFF_DEV_FEAT_SEL, 3'd4, 32'd1));
      push_item(build_access(REQ_WRITE, OFF_DRV_FEAT_SEL, 3'd4, 32'd2));
      push_item(build_access(REQ_WRITE, OFF_DRV_FEAT, 3'd4, 32'hffff_ffff));
      // Out-of-range queue select hides the queue registers
      push_item(build_access(REQ_WRITE, OFF_QUEUE_SEL, 3'd4, 32'd2));
      push_item(build_access(REQ_WRITE, OFF_QUEUE_NUM, 3'd4, 32'd8));
      push_item(build_access(REQ_READ, OFF_QUEUE_MAX, 3'd4, 32'd0));
      push_item(build_access(REQ_WRITE, OFF_QUEUE_SEL, 3'd4, 32'd0));
      push_item(build_access(REQ_WRITE, OFF_QUEUE_NUM, 3'd4, 32'(QMAX + 1)));
      push_item(build_access(REQ_WRITE, OFF_QUEUE_NUM, 3'd4, 32'(QMAX)));
      push_item(build_access(REQ_WRITE, OFF_QUEUE_READY, 3'd4, 32'hffff_ffff));
      push_item(build_access(REQ_WRITE, OFF_QUEUE_NOTIFY, 3'd4, 32'd1));
      push_item(build_access(REQ_WRITE, OFF_QUEUE_NOTIFY, 3'd4, 32'd2));
      // Narrow register read, window overrun, zero width
      push_item(build_access(REQ_READ, OFF_MAGIC, 3'd2, 32'd0));
      push_item(build_access(REQ_READ, 9'h1ff, 3'd4, 32'd0));
      push_item(build_access(REQ_READ, CFG_BASE, 3'd0, 32'd0));
      // Config space: inside, past the end, and an ignored write
      push_item(build_access(REQ_READ, 9'h106, 3'd2, 32'd0));
      push_item(build_access(REQ_READ, 9'h105, 3'd4, 32'd0));
      push_item(build_access(REQ_WRITE, CFG_BASE, 3'd4, 32'hffff_ffff));
      // Link up twice: the second one is no change
      push_item(build_access(REQ_LINK, 9'h0, 3'd0, 32'd0, 1'b1, 1'b0));
      push_item(build_access(REQ_LINK, 9'h1ff, 3'd7, 32'hffff_ffff, 1'b1, 1'b1));
      push_item(build_access(REQ_DONE, 9'h0, 3'd0, 32'd0, 1'b0, 1'b1));
      push_item(build_access(REQ_DONE, 9'h0, 3'd0, 32'd0, 1'b0, 1'b0));
      push_item(build_access(REQ_WRITE, OFF_INT_ACK, 3'd4, 32'hffff_ffff));
      push_item(build_access(REQ_WRITE, OFF_STATUS, 3'd4, ST_DRV_OK | ST_DRIVER | ST_ACK));
      push_item(build_access(REQ_WRITE, OFF_STATUS, 3'd4, 32'd0));
      wait_idle(3);

      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       phase_mac = '1;
            1:       phase_mac = '0;
            2:       phase_mac = {16'($urandom), $urandom};
            default: phase_mac = MAC_RESET;
         endcase
         write_station_mac(phase_mac);
         phase_target = accesses_queued + 137;
         while (accesses_queued < phase_target) begin
            pick = $urandom_range(0, 9);
            if (pick < 2) begin
               add_bringup();
            end else if (pick < 8) begin
               repeat ($urandom_range(4, 12)) push_item(random_traffic_item());
            end else begin
               // Noise: any kind, offset, width and data
               repeat ($urandom_range(1, 6))
                  push_item(build_access(req_kind_type'($urandom_range(0, 3)), 9'($urandom),
                                         3'($urandom), $urandom, 1'($urandom), 1'($urandom)));
            end
         end
         wait_idle(3);
      end

      wait_idle(8);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Sender: bursts of items with random gaps, holding an item until taken
   req_item_type held_item;
   int           burst_left = 0;
   int           gap_left   = 0;

   always @(posedge clock) begin
      logic offering;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         offering = req_bus.valid;
         if (req_bus.valid && req_bus.ready) begin
            predicted_rsp.push_back(apply_access(held_item));
            accesses_taken++;
            offering = 1'b0;
         end
         if (!offering) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (access_queue.size() != 0) begin
               if (burst_left == 0) burst_left = $urandom_range(1, 24);
               held_item = access_queue.pop_front();
               req_bus.req_type             <= held_item.req_type;
               req_bus.offset               <= held_item.offset;
               req_bus.access_width         <= held_item.access_width;
               req_bus.write_data           <= held_item.write_data;
               req_bus.link_up              <= held_item.link_up;
               req_bus.interrupt_suppressed <= held_item.interrupt_suppressed;
               offering = 1'b1;
               burst_left--;
               if (burst_left == 0)
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end
         req_bus.valid <= offering;
      end
   end

   // Receiver: check each response, stall on a changing pattern plus long hold-offs
   int hold_left = 0;
   int hold_mark = 120;
   int mode      = 0;
   int mode_left = 0;

   always @(posedge clock) begin
      rsp_item_type want;
      logic         next_ready;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            rsp_checked++;
            if (predicted_rsp.size() == 0) begin
               $error("response item with none expected");
               error_count++;
            end else begin
               want = predicted_rsp.pop_front();
               if (rsp_bus.read_data !== want.read_data) begin
                  $error("read_data: expected %h, got %h", want.read_data, rsp_bus.read_data);
                  error_count++;
               end
               if (rsp_bus.irq_pending !== want.irq_pending) begin
                  $error("irq_pending: expected %b, got %b", want.irq_pending,
                         rsp_bus.irq_pending);
                  error_count++;
               end
               if (rsp_bus.kick !== want.kick) begin
                  $error("kick: expected %b, got %b", want.kick, rsp_bus.kick);
                  error_count++;
               end
               if (rsp_bus.driver_ok !== want.driver_ok) begin
                  $error("driver_ok: expected %b, got %b", want.driver_ok, rsp_bus.driver_ok);
                  error_count++;
               end
            end
         end

         if (hold_left != 0) begin
            hold_left--;
            next_ready = 1'b0;
         end else if (rsp_checked >= hold_mark) begin
            // Long hold-off so the block fills and backs up its input
            hold_left  = 64;
            hold_mark += 280;
            next_ready = 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(0, 2);
               mode_left = $urandom_range(8, 40);
            end else begin
               mode_left--;
            end
            case (mode)
               0:       next_ready = 1'b1;
               1:       next_ready = $urandom_range(0, 3) != 0;
               default: next_ready = $urandom_range(0, 2) == 0;
            endcase
         end
         rsp_bus.ready <= next_ready;
      end
   end

   initial begin
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

@@ virtio_mmio_net_register_file.f @@
rtl/vnet_pkg.sv
rtl/vnet_if.sv
rtl/vnet_regs.sv
rtl/virtio_mmio_net_register_file.sv
dv/virtio_mmio_net_register_file_tb.sv
